// ===== hdl/rau_pkg.sv =====
// Package: widths, operation and status codes, microcode table for the rational arithmetic unit
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int VALUE_W       = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
    localparam int RESULT_W      = 33;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int SIGN_W        = 2;
    localparam int S_TDATA_W     = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_BITS  = 2 * RESULT_W + SIGN_W;
    localparam int M_TDATA_W     = ((M_TDATA_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_CMP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DENZ = 2'd2;

    localparam logic [SIGN_W-1:0] SGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SGN_NEG  = 2'b11;

    localparam int PC_W   = 5;
    localparam int ACT_W  = 5;
    localparam int COND_W = 4;

    localparam logic [ACT_W-1:0] ACT_NONE    = 5'd0;
    localparam logic [ACT_W-1:0] ACT_MUL_P   = 5'd1;
    localparam logic [ACT_W-1:0] ACT_MUL_Q   = 5'd2;
    localparam logic [ACT_W-1:0] ACT_MUL_D   = 5'd3;
    localparam logic [ACT_W-1:0] ACT_COMB    = 5'd4;
    localparam logic [ACT_W-1:0] ACT_EU_INIT = 5'd5;
    localparam logic [ACT_W-1:0] ACT_EU_DIV  = 5'd6;
    localparam logic [ACT_W-1:0] ACT_EU_STEP = 5'd7;
    localparam logic [ACT_W-1:0] ACT_N_DIV   = 5'd8;
    localparam logic [ACT_W-1:0] ACT_N_TAKE  = 5'd9;
    localparam logic [ACT_W-1:0] ACT_D_DIV   = 5'd10;
    localparam logic [ACT_W-1:0] ACT_D_TAKE  = 5'd11;
    localparam logic [ACT_W-1:0] ACT_SIGN    = 5'd12;
    localparam logic [ACT_W-1:0] ACT_Z_DENZ  = 5'd13;
    localparam logic [ACT_W-1:0] ACT_Z_DIVZ  = 5'd14;
    localparam logic [ACT_W-1:0] ACT_Z_BADOP = 5'd15;
    localparam logic [ACT_W-1:0] ACT_EMIT    = 5'd16;

    localparam logic [COND_W-1:0] C_NEXT        = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
    localparam logic [COND_W-1:0] C_NO_ITEM     = 4'd2;
    localparam logic [COND_W-1:0] C_IN_DEN_ZERO = 4'd3;
    localparam logic [COND_W-1:0] C_DIV_ZERO    = 4'd4;
    localparam logic [COND_W-1:0] C_BAD_OP      = 4'd5;
    localparam logic [COND_W-1:0] C_DEN_ZERO    = 4'd6;
    localparam logic [COND_W-1:0] C_B_ZERO      = 4'd7;
    localparam logic [COND_W-1:0] C_DIV_BUSY    = 4'd8;
    localparam logic [COND_W-1:0] C_OUT_BUSY    = 4'd9;

    localparam logic [PC_W-1:0] P_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] P_CHK_DEN = 5'd1;
    localparam logic [PC_W-1:0] P_CHK_DVZ = 5'd2;
    localparam logic [PC_W-1:0] P_CHK_OP  = 5'd3;
    localparam logic [PC_W-1:0] P_MUL_P   = 5'd4;
    localparam logic [PC_W-1:0] P_MUL_Q   = 5'd5;
    localparam logic [PC_W-1:0] P_MUL_D   = 5'd6;
    localparam logic [PC_W-1:0] P_COMB    = 5'd7;
    localparam logic [PC_W-1:0] P_EU_INIT = 5'd8;
    localparam logic [PC_W-1:0] P_EU_LOOP = 5'd9;
    localparam logic [PC_W-1:0] P_EU_DIV  = 5'd10;
    localparam logic [PC_W-1:0] P_EU_WAIT = 5'd11;
    localparam logic [PC_W-1:0] P_EU_STEP = 5'd12;
    localparam logic [PC_W-1:0] P_REDUCE  = 5'd13;
    localparam logic [PC_W-1:0] P_N_WAIT  = 5'd14;
    localparam logic [PC_W-1:0] P_N_TAKE  = 5'd15;
    localparam logic [PC_W-1:0] P_D_DIV   = 5'd16;
    localparam logic [PC_W-1:0] P_D_WAIT  = 5'd17;
    localparam logic [PC_W-1:0] P_D_TAKE  = 5'd18;
    localparam logic [PC_W-1:0] P_SIGN    = 5'd19;
    localparam logic [PC_W-1:0] P_EMIT    = 5'd20;
    localparam logic [PC_W-1:0] P_RETURN  = 5'd21;
    localparam logic [PC_W-1:0] P_Z_DENZ  = 5'd22;
    localparam logic [PC_W-1:0] P_Z_DIVZ  = 5'd23;
    localparam logic [PC_W-1:0] P_Z_BADOP = 5'd24;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    function automatic uword_t urom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{act: ACT_NONE, cond: C_ALWAYS, target: P_IDLE};
        unique case (pc)
            P_IDLE:    w = '{act: ACT_NONE,    cond: C_NO_ITEM,     target: P_IDLE};
            P_CHK_DEN: w = '{act: ACT_NONE,    cond: C_IN_DEN_ZERO, target: P_Z_DENZ};
            P_CHK_DVZ: w = '{act: ACT_NONE,    cond: C_DIV_ZERO,    target: P_Z_DIVZ};
            P_CHK_OP:  w = '{act: ACT_NONE,    cond: C_BAD_OP,      target: P_Z_BADOP};
            P_MUL_P:   w = '{act: ACT_MUL_P,   cond: C_NEXT,        target: P_IDLE};
            P_MUL_Q:   w = '{act: ACT_MUL_Q,   cond: C_NEXT,        target: P_IDLE};
            P_MUL_D:   w = '{act: ACT_MUL_D,   cond: C_NEXT,        target: P_IDLE};
            P_COMB:    w = '{act: ACT_COMB,    cond: C_NEXT,        target: P_IDLE};
            P_EU_INIT: w = '{act: ACT_EU_INIT, cond: C_DEN_ZERO,    target: P_SIGN};
            P_EU_LOOP: w = '{act: ACT_NONE,    cond: C_B_ZERO,      target: P_REDUCE};
            P_EU_DIV:  w = '{act: ACT_EU_DIV,  cond: C_NEXT,        target: P_IDLE};
            P_EU_WAIT: w = '{act: ACT_NONE,    cond: C_DIV_BUSY,    target: P_EU_WAIT};
            P_EU_STEP: w = '{act: ACT_EU_STEP, cond: C_ALWAYS,      target: P_EU_LOOP};
            P_REDUCE:  w = '{act: ACT_N_DIV,   cond: C_NEXT,        target: P_IDLE};
            P_N_WAIT:  w = '{act: ACT_NONE,    cond: C_DIV_BUSY,    target: P_N_WAIT};
            P_N_TAKE:  w = '{act: ACT_N_TAKE,  cond: C_NEXT,        target: P_IDLE};
            P_D_DIV:   w = '{act: ACT_D_DIV,   cond: C_NEXT,        target: P_IDLE};
            P_D_WAIT:  w = '{act: ACT_NONE,    cond: C_DIV_BUSY,    target: P_D_WAIT};
            P_D_TAKE:  w = '{act: ACT_D_TAKE,  cond: C_NEXT,        target: P_IDLE};
            P_SIGN:    w = '{act: ACT_SIGN,    cond: C_NEXT,        target: P_IDLE};
            P_EMIT:    w = '{act: ACT_EMIT,    cond: C_OUT_BUSY,    target: P_EMIT};
            P_RETURN:  w = '{act: ACT_NONE,    cond: C_ALWAYS,      target: P_IDLE};
            P_Z_DENZ:  w = '{act: ACT_Z_DENZ,  cond: C_ALWAYS,      target: P_EMIT};
            P_Z_DIVZ:  w = '{act: ACT_Z_DIVZ,  cond: C_ALWAYS,      target: P_EMIT};
            P_Z_BADOP: w = '{act: ACT_Z_BADOP, cond: C_ALWAYS,      target: P_EMIT};
            default:   w = '{act: ACT_NONE,    cond: C_ALWAYS,      target: P_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [RESULT_W-1:0] to_result(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[RESULT_W-1:0];
    endfunction

endpackage

// ===== hdl/rau_div.sv =====
// Shift-subtract divider giving truncated quotient and remainder of two signed values
module rau_div
    import rau_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [VALUE_W-1:0]  dividend,
    input  logic signed [VALUE_W-1:0]  divisor,
    output logic                       busy,
    output logic signed [VALUE_W-1:0]  quotient,
    output logic signed [VALUE_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic               busy_reg,   busy_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [VALUE_W-1:0] dmag_reg,   dmag_next;
    logic [VALUE_W-1:0] rem_reg,    rem_next;
    logic [VALUE_W-1:0] quo_reg,    quo_next;
    logic               neg_q_reg,  neg_q_next;
    logic               neg_r_reg,  neg_r_next;

    logic [VALUE_W:0]   trial;
    logic [VALUE_W:0]   diff;
    logic               fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[VALUE_W-1]};
        diff  = trial - {1'b0, dmag_reg};
        fits  = (trial >= {1'b0, dmag_reg});

        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        dmag_next  = dmag_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(VALUE_W);
            dmag_next  = divisor[VALUE_W-1] ? VALUE_W'(-divisor) : VALUE_W'(divisor);
            quo_next   = dividend[VALUE_W-1] ? VALUE_W'(-dividend) : VALUE_W'(dividend);
            rem_next   = '0;
            neg_q_next = dividend[VALUE_W-1] ^ divisor[VALUE_W-1];
            neg_r_next = dividend[VALUE_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg  <= dmag_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign busy      = busy_reg;
    assign quotient  = neg_q_reg ? signed'(-quo_reg) : signed'(quo_reg);
    assign remainder = neg_r_reg ? signed'(-rem_reg) : signed'(rem_reg);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_count_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with an empty count");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == CNT_W'(VALUE_W))
        else $error("divider did not load its count");

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// Top level: microcoded rational arithmetic unit with Euclid reduction
//
//   channel | direction | tdata (low bit up)                  | tuser
//   s_      | in        | left_num, left_den, right_num,      | operation
//           |           | right_den                           |
//   m_      | out       | result_num, result_den, order_sign  | status
//
// One item at a time; a result waits in the output register while the next
// item is taken. Each Euclid remainder step is one run of the shift-subtract
// divider, and two more runs reduce the numerator and denominator. An input
// that is rejected (zero denominator, division by zero or unused code) goes
// to the emit step after its check step, without any arithmetic.
// Reset clears the step counter, divider and output valid; no clearing pass.
// A stalled m_ side holds the sequencer at its emit step.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // left_num, left_den, right_num, right_den
    input  logic [OP_W-1:0]       s_tuser,  // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // result_num, result_den, order_sign, zero fill
    output logic [STATUS_W-1:0]   m_tuser   // status
);

    localparam int OW = OPERAND_WIDTH;

    logic [PC_W-1:0]             pc_reg,     pc_next;
    logic [OP_W-1:0]             op_reg,     op_next;
    logic signed [OW-1:0]        ln_reg,     ln_next;
    logic signed [OW-1:0]        ld_reg,     ld_next;
    logic signed [OW-1:0]        rn_reg,     rn_next;
    logic signed [OW-1:0]        rd_reg,     rd_next;
    logic signed [VALUE_W-1:0]   p_reg,      p_next;
    logic signed [VALUE_W-1:0]   q_reg,      q_next;
    logic signed [VALUE_W-1:0]   num_reg,    num_next;
    logic signed [VALUE_W-1:0]   den_reg,    den_next;
    logic signed [VALUE_W-1:0]   a_reg,      a_next;
    logic signed [VALUE_W-1:0]   b_reg,      b_next;
    logic [SIGN_W-1:0]           sgn_reg,    sgn_next;
    logic [STATUS_W-1:0]         status_reg, status_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]        m_tdata_reg,  m_tdata_next;
    logic [STATUS_W-1:0]         m_tuser_reg,  m_tuser_next;

    uword_t                      uw;
    logic                        jump;
    logic                        accept;
    logic                        out_free;
    logic signed [OW-1:0]        mul_a;
    logic signed [OW-1:0]        mul_b;
    logic signed [2*OW-1:0]      mul_y;
    logic signed [VALUE_W-1:0]   mul_ext;
    logic signed [VALUE_W-1:0]   ln_ext;
    logic signed [VALUE_W-1:0]   rn_ext;
    logic signed [VALUE_W-1:0]   ld_ext;
    logic                        is_addsub;
    logic                        is_sub;

    logic                        div_start;
    logic signed [VALUE_W-1:0]   div_dividend;
    logic signed [VALUE_W-1:0]   div_divisor;
    logic                        div_busy;
    logic signed [VALUE_W-1:0]   div_quo;
    logic signed [VALUE_W-1:0]   div_rem;

    rau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign uw       = urom(pc_reg);
    assign s_tready = (pc_reg == P_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ln_ext    = VALUE_W'(ln_reg);
    assign rn_ext    = VALUE_W'(rn_reg);
    assign ld_ext    = VALUE_W'(ld_reg);
    assign is_addsub = (op_reg == OP_ADD) || (op_reg == OP_SUB) || (op_reg == OP_CMP);
    assign is_sub    = (op_reg != OP_ADD);

    // one shared multiplier, operands picked by the current step
    always_comb
    begin
        mul_a = ln_reg;
        mul_b = rd_reg;
        unique case (uw.act)
            ACT_MUL_P:
            begin
                mul_a = ln_reg;
                mul_b = (op_reg == OP_MUL) ? rn_reg : rd_reg;
            end
            ACT_MUL_Q:
            begin
                mul_a = rn_reg;
                mul_b = ld_reg;
            end
            ACT_MUL_D:
            begin
                mul_a = ld_reg;
                mul_b = (op_reg == OP_DIV) ? rn_reg : rd_reg;
            end
            default:
            begin
                mul_a = ln_reg;
                mul_b = rd_reg;
            end
        endcase
        mul_y   = mul_a * mul_b;
        mul_ext = VALUE_W'(mul_y);
    end

    always_comb
    begin
        div_start    = (uw.act == ACT_EU_DIV) || (uw.act == ACT_N_DIV) || (uw.act == ACT_D_DIV);
        div_dividend = a_reg;
        div_divisor  = b_reg;
        unique case (uw.act)
            ACT_N_DIV:
            begin
                div_dividend = num_reg;
                div_divisor  = a_reg;
            end
            ACT_D_DIV:
            begin
                div_dividend = den_reg;
                div_divisor  = a_reg;
            end
            default:
            begin
                div_dividend = a_reg;
                div_divisor  = b_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (uw.cond)
            C_NEXT:        jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_ITEM:     jump = !s_tvalid;
            C_IN_DEN_ZERO: jump = (ld_reg == '0) || (rd_reg == '0);
            C_DIV_ZERO:    jump = (op_reg == OP_DIV) && (rn_reg == '0);
            C_BAD_OP:      jump = (op_reg > OP_CMP);
            C_DEN_ZERO:    jump = (den_reg == '0);
            C_B_ZERO:      jump = (b_reg == '0);
            C_DIV_BUSY:    jump = div_busy;
            C_OUT_BUSY:    jump = !out_free;
            default:       jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        op_next       = op_reg;
        ln_next       = ln_reg;
        ld_next       = ld_reg;
        rn_next       = rn_reg;
        rd_next       = rd_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        sgn_next      = sgn_reg;
        status_next   = status_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (accept)
        begin
            op_next     = s_tuser;
            ln_next     = s_tdata[OW-1:0];
            ld_next     = s_tdata[2*OW-1:OW];
            rn_next     = s_tdata[3*OW-1:2*OW];
            rd_next     = s_tdata[4*OW-1:3*OW];
            num_next    = '0;
            den_next    = VALUE_W'(1);
            sgn_next    = SGN_ZERO;
            status_next = ST_OK;
        end

        unique case (uw.act)
            ACT_MUL_P:   p_next = mul_ext;
            ACT_MUL_Q:   q_next = mul_ext;
            ACT_MUL_D:   den_next = mul_ext;
            ACT_COMB:
            begin
                if (is_addsub)
                begin
                    if (ld_reg == rd_reg)
                    begin
                        num_next = is_sub ? ln_ext - rn_ext : ln_ext + rn_ext;
                        den_next = ld_ext;
                    end
                    else
                    begin
                        num_next = is_sub ? p_reg - q_reg : p_reg + q_reg;
                    end
                end
                else
                begin
                    num_next = p_reg;
                end
            end
            ACT_EU_INIT:
            begin
                a_next = num_reg;
                b_next = den_reg;
            end
            ACT_EU_STEP:
            begin
                a_next = b_reg;
                b_next = div_rem;
            end
            ACT_N_TAKE:  num_next = div_quo;
            ACT_D_TAKE:  den_next = div_quo;
            ACT_SIGN:
            begin
                if (op_reg != OP_CMP)
                begin
                    sgn_next = SGN_ZERO;
                end
                else if (num_reg < 0)
                begin
                    sgn_next = SGN_NEG;
                end
                else if (num_reg != '0)
                begin
                    sgn_next = SGN_POS;
                end
                else
                begin
                    sgn_next = SGN_ZERO;
                end
            end
            ACT_Z_DENZ:
            begin
                num_next    = '0;
                den_next    = VALUE_W'(1);
                sgn_next    = SGN_ZERO;
                status_next = ST_DENZ;
            end
            ACT_Z_DIVZ:
            begin
                num_next    = '0;
                den_next    = VALUE_W'(1);
                sgn_next    = SGN_ZERO;
                status_next = ST_DIVZ;
            end
            ACT_Z_BADOP:
            begin
                num_next    = '0;
                den_next    = VALUE_W'(1);
                sgn_next    = SGN_ZERO;
                status_next = ST_OK;
            end
            ACT_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({sgn_reg, to_result(den_reg), to_result(num_reg)});
                    m_tuser_next  = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= P_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ln_reg      <= ln_next;
        ld_reg      <= ld_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        sgn_reg     <= sgn_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == P_IDLE) |-> !div_busy)
        else $error("sequencer idle while divider runs");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second transaction taken before the first finished");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_DIVZ) || (m_tuser == ST_DENZ))
        else $error("unknown status on result");

    a_sign_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2*RESULT_W+SIGN_W-1:2*RESULT_W] != SGN_ZERO)
        |-> m_tuser == ST_OK)
        else $error("order sign set on a rejected transaction");

endmodule

// ===== dv/rau_checker.sv =====
// Checker: watches both channels of the rational arithmetic unit, predicts each result and compares
module rau_checker
    import rau_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // left_num, left_den, right_num, right_den
    input  logic [OP_W-1:0]      s_tuser,  // operation
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // result_num, result_den, order_sign, zero fill
    input  logic [STATUS_W-1:0]  m_tuser,  // status
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic [RESULT_W-1:0] num;
        logic [RESULT_W-1:0] den;
        logic [SIGN_W-1:0]   order_sign;
        logic [STATUS_W-1:0] status;
    } fraction_t;

    localparam int MAX_REPORTS = 10;

    fraction_t expected_fractions[$];

    function automatic longint trunc_quot(input longint a, input longint b);
        return (b == -1) ? -a : a / b;
    endfunction

    function automatic longint trunc_rem(input longint a, input longint b);
        return (b == -1) ? 64'sd0 : a % b;
    endfunction

    // Euclid with truncated remainder: the sign of the divisor follows the operands
    function automatic longint euclid_gcd(input longint a, input longint b);
        longint t;
        while (b != 0)
        begin
            t = b;
            b = trunc_rem(a, b);
            a = t;
        end
        return a;
    endfunction

    function automatic fraction_t predict_fraction(
        input logic [OP_W-1:0]                 op,
        input logic signed [OPERAND_WIDTH-1:0] left_num_w,
        input logic signed [OPERAND_WIDTH-1:0] left_den_w,
        input logic signed [OPERAND_WIDTH-1:0] right_num_w,
        input logic signed [OPERAND_WIDTH-1:0] right_den_w
    );
        fraction_t           r;
        longint              ln;
        longint              ld;
        longint              rn;
        longint              rd;
        longint              num;
        longint              den;
        longint              g;
        logic [STATUS_W-1:0] st;
        logic [SIGN_W-1:0]   sgn;
        ln  = left_num_w;
        ld  = left_den_w;
        rn  = right_num_w;
        rd  = right_den_w;
        num = 0;
        den = 1;
        st  = ST_OK;
        sgn = SGN_ZERO;
        if (ld == 0 || rd == 0)
            st = ST_DENZ;
        else
        begin
            case (op)
                OP_ADD, OP_SUB, OP_CMP:
                begin
                    if (ld == rd)
                    begin
                        num = (op == OP_ADD) ? ln + rn : ln - rn;
                        den = ld;
                    end
                    else
                    begin
                        num = (op == OP_ADD) ? ln * rd + rn * ld : ln * rd - rn * ld;
                        den = ld * rd;
                    end
                end
                OP_MUL:
                begin
                    num = ln * rn;
                    den = ld * rd;
                end
                OP_DIV:
                begin
                    if (rn == 0)
                        st = ST_DIVZ;
                    else
                    begin
                        num = ln * rd;
                        den = ld * rn;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (st == ST_OK && den != 0)
        begin
            g   = euclid_gcd(num, den);
            num = trunc_quot(num, g);
            den = trunc_quot(den, g);
        end
        if (st == ST_OK && op == OP_CMP)
            sgn = (num < 0) ? SGN_NEG : ((num > 0) ? SGN_POS : SGN_ZERO);
        r.num        = num[RESULT_W-1:0];
        r.den        = den[RESULT_W-1:0];
        r.order_sign = sgn;
        r.status     = st;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input fraction_t want, input fraction_t got);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s: got %0d/%0d order %0d status %0d, expected %0d/%0d order %0d status %0d",
                     $realtime, what,
                     $signed(got.num), $signed(got.den), $signed(got.order_sign), got.status,
                     $signed(want.num), $signed(want.den), $signed(want.order_sign), want.status);
        mismatches++;
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin : watch
        fraction_t got;
        fraction_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.num        = m_tdata[RESULT_W-1:0];
                got.den        = m_tdata[2*RESULT_W-1:RESULT_W];
                got.order_sign = m_tdata[2*RESULT_W+SIGN_W-1:2*RESULT_W];
                got.status     = m_tuser;
                if (expected_fractions.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = expected_fractions.pop_front();
                    if (got.num !== want.num || got.den !== want.den
                        || got.order_sign !== want.order_sign || got.status !== want.status)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
                expected_fractions.push_back(predict_fraction(
                    s_tuser,
                    s_tdata[OPERAND_WIDTH-1:0],
                    s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH],
                    s_tdata[3*OPERAND_WIDTH-1:2*OPERAND_WIDTH],
                    s_tdata[4*OPERAND_WIDTH-1:3*OPERAND_WIDTH]));
            outstanding <= expected_fractions.size();
        end
    end

endmodule

// ===== dv/rational_arithmetic_unit_tb.sv =====
// Testbench top: clock, reset, fraction stimulus with bursts and stalls, and the final verdict
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int  RANDOM_ITEMS = 1300;
    localparam int  DRAIN_CYCLES = 2500;
    localparam int  CYCLE_LIMIT  = 10_000_000;
    localparam int  MAX_OPERAND  = 2 ** (OPERAND_WIDTH - 1) - 1;
    localparam int  MIN_OPERAND  = -(2 ** (OPERAND_WIDTH - 1));
    localparam int  FIRST_UNUSED = int'(OP_CMP) + 1;
    localparam int  LAST_UNUSED  = 2 ** OP_W - 1;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int mismatches;
    int outstanding;
    int cycles;
    int burst_left;
    int ready_hold;
    int ready_phase;

    rational_arithmetic_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rau_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // long ready stretches, short random toggling and long holds, in turn
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            ready_phase <= ready_phase + 1;
            case (ready_phase % 8)
                0:
                begin
                    m_tready   <= 1'b1;
                    ready_hold <= $urandom_range(50, 400);
                end
                6:
                begin
                    m_tready   <= 1'b0;
                    ready_hold <= $urandom_range(5, 80);
                end
                default:
                begin
                    m_tready   <= 1'($urandom_range(0, 1));
                    ready_hold <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    task automatic send_fractions(
        input logic [OP_W-1:0]                 op,
        input logic signed [OPERAND_WIDTH-1:0] left_num,
        input logic signed [OPERAND_WIDTH-1:0] left_den,
        input logic signed [OPERAND_WIDTH-1:0] right_num,
        input logic signed [OPERAND_WIDTH-1:0] right_den
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tdata  <= S_TDATA_W'({right_den, right_num, left_den, left_num});
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand(input bit nonzero);
        logic signed [OPERAND_WIDTH-1:0] v;
        do
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    case ($urandom_range(0, 4))
                        0:       v = OPERAND_WIDTH'(MIN_OPERAND);
                        1:       v = OPERAND_WIDTH'(MAX_OPERAND);
                        2:       v = -1;
                        3:       v = 1;
                        default: v = '0;
                    endcase
                end
                2, 3, 4: v = OPERAND_WIDTH'(int'($urandom_range(0, 128)) - 64);
                default: v = OPERAND_WIDTH'($urandom);
            endcase
        end
        while (nonzero && v == 0);
        return v;
    endfunction

    task automatic send_random_fractions();
        int                              pick;
        logic [OP_W-1:0]                 op;
        logic signed [OPERAND_WIDTH-1:0] ln;
        logic signed [OPERAND_WIDTH-1:0] ld;
        logic signed [OPERAND_WIDTH-1:0] rn;
        logic signed [OPERAND_WIDTH-1:0] rd;
        pick = $urandom_range(0, 99);
        op   = OP_W'($urandom_range(int'(OP_ADD), int'(OP_CMP)));
        ln   = pick_operand(1'b0);
        ld   = pick_operand(1'b1);
        rn   = pick_operand(1'b0);
        rd   = pick_operand(1'b1);
        if (pick < 20)
            rd = ld;
        else if (pick < 28)
        begin
            op = OP_DIV;
            rn = '0;
        end
        else if (pick < 36)
        begin
            case ($urandom_range(0, 2))
                0:       ld = '0;
                1:       rd = '0;
                default:
                begin
                    ld = '0;
                    rd = '0;
                end
            endcase
        end
        else if (pick < 42)
            op = OP_W'($urandom_range(FIRST_UNUSED, LAST_UNUSED));
        else if (pick < 48)
        begin
            ln = '0;
            if ($urandom_range(0, 1) == 1)
                rn = '0;
        end
        send_fractions(op, ln, ld, rn, rd);
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_ADD;
        m_tready    = 1'b0;
        cycles      = 0;
        burst_left  = 0;
        ready_hold  = 0;
        ready_phase = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fractions(OP_ADD, 1, 2, 1, 3);
        send_fractions(OP_SUB, 3, 4, 1, 4);
        send_fractions(OP_MUL, MIN_OPERAND, MAX_OPERAND, MAX_OPERAND, MIN_OPERAND);
        send_fractions(OP_DIV, MAX_OPERAND, MIN_OPERAND, MIN_OPERAND, MAX_OPERAND);
        send_fractions(OP_CMP, 1, 3, 1, 3);
        send_fractions(OP_CMP, -1, 2, 1, 2);
        send_fractions(OP_CMP, 5, 7, -3, -4);
        send_fractions(OP_CMP, -7, -9, 2, -9);
        send_fractions(OP_ADD, 0, 5, 0, -7);
        send_fractions(OP_DIV, 0, 3, 5, 7);
        send_fractions(OP_DIV, 4, 9, 0, 5);
        send_fractions(OP_ADD, 1, 0, 2, 3);
        send_fractions(OP_DIV, 1, 3, 0, 0);
        send_fractions(OP_CMP, 1, 0, 1, 0);
        for (int code = FIRST_UNUSED; code <= LAST_UNUSED; code++)
            send_fractions(OP_W'(code), MAX_OPERAND, 3, -5, 7);
        send_fractions(OP_ADD, MAX_OPERAND, 1, MAX_OPERAND, 1);
        send_fractions(OP_ADD, MIN_OPERAND, -1, MIN_OPERAND, MAX_OPERAND);
        send_fractions(OP_SUB, MIN_OPERAND, MIN_OPERAND, MAX_OPERAND, MAX_OPERAND);
        send_fractions(OP_MUL, -1, -1, -1, -1);
        send_fractions(OP_ADD, MAX_OPERAND, MAX_OPERAND - 1, MIN_OPERAND, MAX_OPERAND - 2);
        send_fractions(OP_SUB, 12, -18, 4, 6);
        send_fractions(OP_MUL, 0, MIN_OPERAND, MIN_OPERAND, -1);

        repeat (RANDOM_ITEMS) send_random_fractions();
        s_tvalid <= 1'b0;

        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== rational_arithmetic_unit.f =====
hdl/rau_pkg.sv
hdl/rau_div.sv
hdl/rational_arithmetic_unit.sv
dv/rau_checker.sv
dv/rational_arithmetic_unit_tb.sv
